### design/tpfa_pkg.sv
// Package for the two-region page frame allocator.
// Holds the region sizes, field widths, status codes and the per-item context type.
// Depends on nothing; imported by the top level.
`timescale 1ns / 1ps

package tpfa_pkg;

  // Region sizes and page geometry.
  localparam int KERNEL_PAGES = 1024;
  localparam int USER_PAGES   = 4096;
  localparam int PAGE_SHIFT   = 12;

  // Fixed field widths.
  localparam int ADDR_W   = 52;
  localparam int BASE_W   = 40;
  localparam int FREE_W   = 13;
  localparam int STATUS_W = 2;

  localparam logic [BASE_W-1:0] BASE_RESET = BASE_W'(524288);

  // Derived widths: stack offsets, free counts and the page number compare.
  localparam int KOFF_W = (KERNEL_PAGES > 1) ? $clog2(KERNEL_PAGES) : 1;
  localparam int UOFF_W = (USER_PAGES > 1) ? $clog2(USER_PAGES) : 1;
  localparam int KCNT_W = $clog2(KERNEL_PAGES + 1);
  localparam int UCNT_W = $clog2(USER_PAGES + 1);
  localparam int OFF_W  = (KOFF_W > UOFF_W) ? KOFF_W : UOFF_W;
  localparam int CNT_MX = (KCNT_W > UCNT_W) ? KCNT_W : UCNT_W;
  localparam int CNT_W  = (CNT_MX > FREE_W) ? CNT_MX : FREE_W;
  localparam int PNUM_W = ADDR_W - PAGE_SHIFT;
  localparam int CMP_W  = ((PNUM_W > BASE_W + 1) ? PNUM_W : BASE_W + 1) + 1;

  // Operation codes on the mode field.
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_BADADDR = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  // Context of one item carried from the decision cycle into the result cycle.
  typedef struct packed {
    status_t           status;
    logic              pop_ok;
    logic              kern;
    logic              from_mem;
    logic [OFF_W-1:0]  init_off;
    logic [FREE_W-1:0] free_pages;
  } op_t;

endpackage

### design/two_region_page_frame_allocator.sv
// Top level of the two-region page frame allocator: free stacks, counts and handshakes.
// Depends on tpfa_pkg for sizes, widths, status codes and the item context type.
`timescale 1ns / 1ps

//  Channel   Direction  Handshake                 Payload
//  cfg       in         cfg_wr_en                 cfg_wr_data (region base page number)
//  in        in         in_valid / in_stall       in_mode, in_kern_sel, in_page_address
//  out       out        out_valid / out_stall     out_granted_address, out_status,
//                                                 out_free_pages
//
// Each item passes through a decision step and a result step: the first decides the item from
// the free counts and issues at most one access to the selected region's stack memory, the
// second collects the registered read data and forms the result. A finished result sits in
// an output register, so the next item is taken while it waits. in_stall is high during the
// result step, which holds while the output register is still full and out_stall is high.
// There is no clearing pass after reset: a low-water mark per region stands in for the
// reset contents of the stacks.

module two_region_page_frame_allocator
  import tpfa_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,

  input  logic              cfg_wr_en,
  input  logic [BASE_W-1:0] cfg_wr_data,

  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_mode,
  input  logic              in_kern_sel,
  input  logic [ADDR_W-1:0] in_page_address,

  output logic                out_valid,
  input  logic                out_stall,
  output logic [ADDR_W-1:0]   out_granted_address,
  output logic [STATUS_W-1:0] out_status,
  output logic [FREE_W-1:0]   out_free_pages
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  logic [BASE_W-1:0] base_r;

  // Free counts and low-water marks. Every stack entry below a region's low-water mark
  // has never been written since reset, so its value is taken to be its own index. A pop always
  // takes the entry just below the count; when the count equals the low-water mark that
  // entry is such an untouched one, and its value is its index.
  logic [KCNT_W-1:0] kcnt_r, kcnt_nxt, klw_r, klw_nxt;
  logic [UCNT_W-1:0] ucnt_r, ucnt_nxt, ulw_r, ulw_nxt;

  op_t op_r, op_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0]   out_addr_r, out_addr_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [FREE_W-1:0]   out_free_r, out_free_nxt;

  // Stack memories, one port each, read data registered.
  logic [KOFF_W-1:0] kstack_mem [KERNEL_PAGES];
  logic [UOFF_W-1:0] ustack_mem [USER_PAGES];
  logic [KOFF_W-1:0] k_rdata_r, k_addr, k_wdata;
  logic [UOFF_W-1:0] u_rdata_r, u_addr, u_wdata;
  logic              k_we, k_re, u_we, u_re;

  logic              acc;
  logic              exec_done;
  logic [KCNT_W-1:0] k_dec;
  logic [UCNT_W-1:0] u_dec;
  logic              k_empty, k_full, u_empty, u_full;

  logic [CMP_W-1:0]  pnum_x, first_x, region_pages;
  logic [CMP_W:0]    diff;
  logic              bad_addr;

  logic [CMP_W-1:0]  first_e, page_sum;
  logic [CMP_W+PAGE_SHIFT-1:0] page_bytes;
  logic [OFF_W-1:0]  pop_off;
  logic [CNT_W-1:0]  cnt_sel;

  status_t           status_v;
  logic              pop_ok_v, from_mem_v;
  logic [OFF_W-1:0]  init_off_v;

  assign acc       = in_valid && (state_r == S_IDLE);
  assign in_stall  = (state_r != S_IDLE);
  assign exec_done = (state_r == S_EXEC) && (!out_valid_r || !out_stall);

  assign k_dec   = kcnt_r - KCNT_W'(1);
  assign u_dec   = ucnt_r - UCNT_W'(1);
  assign k_empty = (kcnt_r == '0) || (kcnt_r > KCNT_W'(KERNEL_PAGES));
  assign u_empty = (ucnt_r == '0) || (ucnt_r > UCNT_W'(USER_PAGES));
  assign k_full  = (kcnt_r >= KCNT_W'(KERNEL_PAGES));
  assign u_full  = (ucnt_r >= UCNT_W'(USER_PAGES));

  // Free address check: alignment, then the page number against the selected region.
  // The extra top bit of the subtraction flags a page below the region's first page.
  assign pnum_x       = CMP_W'(in_page_address[ADDR_W-1:PAGE_SHIFT]);
  assign first_x      = CMP_W'(base_r) + (in_kern_sel ? CMP_W'(0) : CMP_W'(KERNEL_PAGES));
  assign region_pages = in_kern_sel ? CMP_W'(KERNEL_PAGES) : CMP_W'(USER_PAGES);
  assign diff         = {1'b0, pnum_x} - {1'b0, first_x};
  assign bad_addr     = (|in_page_address[PAGE_SHIFT-1:0]) || diff[CMP_W] ||
                        (diff[CMP_W-1:0] >= region_pages);

  // Result cycle: page offset from the memory or from an untouched entry, then the
  // byte address of the page, taken modulo the address width.
  assign pop_off    = op_r.from_mem ? (op_r.kern ? OFF_W'(k_rdata_r) : OFF_W'(u_rdata_r))
                                    : op_r.init_off;
  assign first_e    = CMP_W'(base_r) + (op_r.kern ? CMP_W'(0) : CMP_W'(KERNEL_PAGES));
  assign page_sum   = first_e + CMP_W'(pop_off);
  assign page_bytes = {page_sum, {PAGE_SHIFT{1'b0}}};

  always_comb begin
    state_nxt      = state_r;
    kcnt_nxt       = kcnt_r;
    klw_nxt        = klw_r;
    ucnt_nxt       = ucnt_r;
    ulw_nxt        = ulw_r;
    op_nxt         = op_r;
    out_valid_nxt  = out_valid_r;
    out_addr_nxt   = out_addr_r;
    out_status_nxt = out_status_r;
    out_free_nxt   = out_free_r;
    k_we           = 1'b0;
    k_re           = 1'b0;
    u_we           = 1'b0;
    u_re           = 1'b0;
    k_addr         = k_dec[KOFF_W-1:0];
    u_addr         = u_dec[UOFF_W-1:0];
    k_wdata        = diff[KOFF_W-1:0];
    u_wdata        = diff[UOFF_W-1:0];
    status_v       = ST_OK;
    pop_ok_v       = 1'b0;
    from_mem_v     = 1'b1;
    init_off_v     = '0;
    cnt_sel        = '0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          if (in_mode == MODE_ALLOC) begin
            if (in_kern_sel) begin
              if (k_empty) begin
                status_v = ST_EMPTY;
              end else begin
                pop_ok_v = 1'b1;
                kcnt_nxt = k_dec;
                if (kcnt_r == klw_r) begin
                  from_mem_v = 1'b0;
                  klw_nxt    = k_dec;
                  init_off_v = OFF_W'(k_dec[KOFF_W-1:0]);
                end else begin
                  k_re = 1'b1;
                end
              end
            end else begin
              if (u_empty) begin
                status_v = ST_EMPTY;
              end else begin
                pop_ok_v = 1'b1;
                ucnt_nxt = u_dec;
                if (ucnt_r == ulw_r) begin
                  from_mem_v = 1'b0;
                  ulw_nxt    = u_dec;
                  init_off_v = OFF_W'(u_dec[UOFF_W-1:0]);
                end else begin
                  u_re = 1'b1;
                end
              end
            end
          end else begin
            if (bad_addr) begin
              status_v = ST_BADADDR;
            end else if (in_kern_sel) begin
              if (k_full) begin
                status_v = ST_FULL;
              end else begin
                k_we     = 1'b1;
                k_addr   = kcnt_r[KOFF_W-1:0];
                kcnt_nxt = kcnt_r + KCNT_W'(1);
              end
            end else begin
              if (u_full) begin
                status_v = ST_FULL;
              end else begin
                u_we     = 1'b1;
                u_addr   = ucnt_r[UOFF_W-1:0];
                ucnt_nxt = ucnt_r + UCNT_W'(1);
              end
            end
          end

          cnt_sel   = in_kern_sel ? CNT_W'(kcnt_nxt) : CNT_W'(ucnt_nxt);
          op_nxt    = '{status:     status_v,
                        pop_ok:     pop_ok_v,
                        kern:       in_kern_sel,
                        from_mem:   from_mem_v,
                        init_off:   init_off_v,
                        free_pages: cnt_sel[FREE_W-1:0]};
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec_done) begin
          out_valid_nxt  = 1'b1;
          out_addr_nxt   = op_r.pop_ok ? page_bytes[ADDR_W-1:0] : '0;
          out_status_nxt = op_r.status;
          out_free_nxt   = op_r.free_pages;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      base_r      <= BASE_RESET;
      kcnt_r      <= KCNT_W'(KERNEL_PAGES);
      klw_r       <= KCNT_W'(KERNEL_PAGES);
      ucnt_r      <= UCNT_W'(USER_PAGES);
      ulw_r       <= UCNT_W'(USER_PAGES);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      kcnt_r      <= kcnt_nxt;
      klw_r       <= klw_nxt;
      ucnt_r      <= ucnt_nxt;
      ulw_r       <= ulw_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        base_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    out_addr_r   <= out_addr_nxt;
    out_status_r <= out_status_nxt;
    out_free_r   <= out_free_nxt;
  end

  always_ff @(posedge clk) begin
    if (k_we) begin
      kstack_mem[k_addr] <= k_wdata;
    end
    if (k_re) begin
      k_rdata_r <= kstack_mem[k_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (u_we) begin
      ustack_mem[u_addr] <= u_wdata;
    end
    if (u_re) begin
      u_rdata_r <= ustack_mem[u_addr];
    end
  end

  assign out_valid           = out_valid_r;
  assign out_granted_address = out_addr_r;
  assign out_status          = out_status_r;
  assign out_free_pages      = out_free_r;

endmodule

### sim/frame_alloc_checker.sv
`timescale 1ns / 1ps
// Checker for the two-region page frame allocator: tracks the region base writes and
// predicts every result from its own copy of the free stacks, then compares field by field.
// Depends on tpfa_pkg for page counts, field widths, operation and status codes.

module frame_alloc_checker
  import tpfa_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [BASE_W-1:0]   cfg_wr_data,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic                in_mode,
  input  logic                in_kern_sel,
  input  logic [ADDR_W-1:0]   in_page_address,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic [ADDR_W-1:0]   out_granted_address,
  input  logic [STATUS_W-1:0] out_status,
  input  logic [FREE_W-1:0]   out_free_pages,
  output int                  mismatches,
  output int                  outstanding
);

  typedef struct packed {
    logic [ADDR_W-1:0] granted;
    status_t           status;
    logic [FREE_W-1:0] free_pages;
  } frame_result_t;

  logic [BASE_W-1:0] base_page;
  logic [KOFF_W-1:0] kern_stack [KERNEL_PAGES];
  logic [UOFF_W-1:0] user_stack [USER_PAGES];
  int unsigned       kern_free;
  int unsigned       user_free;
  frame_result_t     grants_due [$];
  frame_result_t     want;

  task automatic report_mismatch(string what, logic [63:0] want_v, logic [63:0] got_v);
    $display("%0t ns: %s: expected 0x%0h, got 0x%0h", $time, what, want_v, got_v);
    mismatches++;
  endtask

  // Applies one item to the local stacks and returns the result the block must produce.
  function automatic frame_result_t predict_frame_op(logic mode, logic kern,
                                                     logic [ADDR_W-1:0] addr);
    frame_result_t r;
    logic [63:0]   region_first;
    logic [63:0]   pnum;
    int unsigned   pages;
    int unsigned   cnt;
    r.granted    = '0;
    r.status     = ST_OK;
    region_first = 64'(base_page) + (kern ? 64'd0 : 64'(KERNEL_PAGES));
    pages        = kern ? KERNEL_PAGES : USER_PAGES;
    cnt          = kern ? kern_free : user_free;
    if (mode == MODE_ALLOC) begin
      if (cnt == 0) begin
        r.status = ST_EMPTY;
      end else begin
        cnt--;
        pnum = region_first + (kern ? 64'(kern_stack[cnt]) : 64'(user_stack[cnt]));
        r.granted = ADDR_W'(pnum << PAGE_SHIFT);
      end
    end else begin
      pnum = 64'(addr >> PAGE_SHIFT);
      if (addr[PAGE_SHIFT-1:0] != '0 || pnum < region_first ||
          pnum - region_first >= 64'(pages)) begin
        r.status = ST_BADADDR;
      end else if (cnt >= pages) begin
        r.status = ST_FULL;
      end else begin
        if (kern) begin
          kern_stack[cnt] = KOFF_W'(pnum - region_first);
        end else begin
          user_stack[cnt] = UOFF_W'(pnum - region_first);
        end
        cnt++;
      end
    end
    if (kern) begin
      kern_free = cnt;
    end else begin
      user_free = cnt;
    end
    r.free_pages = FREE_W'(cnt);
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      mismatches = 0;
      base_page  = BASE_RESET;
      for (int i = 0; i < KERNEL_PAGES; i++) kern_stack[i] = KOFF_W'(i);
      for (int i = 0; i < USER_PAGES; i++) user_stack[i] = UOFF_W'(i);
      kern_free = KERNEL_PAGES;
      user_free = USER_PAGES;
      grants_due.delete();
    end else begin
      if (cfg_wr_en) begin
        base_page = cfg_wr_data;
      end
      if (out_valid && !out_stall) begin
        if (grants_due.size() == 0) begin
          report_mismatch("result with nothing expected, status", 64'd0, 64'(out_status));
        end else begin
          want = grants_due.pop_front();
          if (out_granted_address !== want.granted) begin
            report_mismatch("granted_address", 64'(want.granted), 64'(out_granted_address));
          end
          if (out_status !== want.status) begin
            report_mismatch("status", 64'(want.status), 64'(out_status));
          end
          if (out_free_pages !== want.free_pages) begin
            report_mismatch("free_pages", 64'(want.free_pages), 64'(out_free_pages));
          end
        end
      end
      if (in_valid && !in_stall) begin
        grants_due.push_back(predict_frame_op(in_mode, in_kern_sel, in_page_address));
      end
    end
    outstanding <= grants_due.size();
  end

endmodule

### sim/two_region_page_frame_allocator_tb.sv
`timescale 1ns / 1ps
// Testbench top for the two-region page frame allocator: drives requests, out_stall and
// base writes, and gives the verdict. Depends on tpfa_pkg, the block and frame_alloc_checker.

module two_region_page_frame_allocator_tb;
  import tpfa_pkg::*;

  // The run is cut off here.
  localparam int CYCLE_LIMIT = 100_000;
  // The receiver holds off once for this long, after this many results, to fill the block.
  localparam int LONG_HOLD   = 120;
  localparam int HOLD_AFTER  = 230;

  // Codes on the region select field.
  localparam logic SEL_KERN = 1'b1;
  localparam logic SEL_USER = 1'b0;

  logic                clk;
  logic                rst_n           = 1'b0;
  logic                cfg_wr_en       = 1'b0;
  logic [BASE_W-1:0]   cfg_wr_data     = '0;
  logic                in_valid        = 1'b0;
  logic                in_stall;
  logic                in_mode         = MODE_ALLOC;
  logic                in_kern_sel     = SEL_KERN;
  logic [ADDR_W-1:0]   in_page_address = '0;
  logic                out_valid;
  logic                out_stall       = 1'b1;
  logic [ADDR_W-1:0]   out_granted_address;
  logic [STATUS_W-1:0] out_status;
  logic [FREE_W-1:0]   out_free_pages;

  int mismatches;
  int outstanding;
  int cycle_count = 0;

  // When set, neither side inserts gaps, which gives back-to-back stretches.
  logic no_idle = 1'b0;

  // The stimulus keeps its own copy of the base so it can aim at region edges.
  logic [BASE_W-1:0] cur_base = BASE_RESET;

  two_region_page_frame_allocator uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_mode             (in_mode),
    .in_kern_sel         (in_kern_sel),
    .in_page_address     (in_page_address),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_granted_address (out_granted_address),
    .out_status          (out_status),
    .out_free_pages      (out_free_pages)
  );

  frame_alloc_checker chk (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_mode             (in_mode),
    .in_kern_sel         (in_kern_sel),
    .in_page_address     (in_page_address),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_granted_address (out_granted_address),
    .out_status          (out_status),
    .out_free_pages      (out_free_pages),
    .mismatches          (mismatches),
    .outstanding         (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // First page number of a region under the current base, at 64 bits like the compare.
  function automatic logic [63:0] region_first(logic kern);
    return 64'(cur_base) + (kern ? 64'd0 : 64'(KERNEL_PAGES));
  endfunction

  function automatic int unsigned region_pages(logic kern);
    return kern ? KERNEL_PAGES : USER_PAGES;
  endfunction

  // Byte address of a page at a given offset from the region start. An offset of all
  // ones lands on the page just below the region.
  function automatic logic [ADDR_W-1:0] page_addr(logic kern, logic [63:0] off);
    return ADDR_W'((region_first(kern) + off) << PAGE_SHIFT);
  endfunction

  function automatic logic [ADDR_W-1:0] random_addr();
    return ADDR_W'({$urandom, $urandom});
  endfunction

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 6);
  endfunction

  // Offers one item and returns in the time step of the edge that accepted it. Valid is
  // only lowered when a gap is drawn, so a back-to-back item keeps it high.
  task automatic send_op(logic mode, logic kern, logic [ADDR_W-1:0] addr);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_mode         <= mode;
    in_kern_sel     <= kern;
    in_page_address <= addr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Waits until every result has come back, then lets the block drain so that it is idle.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_base(logic [BASE_W-1:0] value);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    cur_base     = value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Mostly well-formed traffic: allocations and aligned frees inside the chosen region,
  // which keep the stacks moving. The rest is misaligned frees, frees just outside the
  // region or into the other region, and fully random items.
  task automatic send_random_op(int alloc_pct);
    int               pick;
    logic             kern;
    logic [63:0]      off;
    logic [ADDR_W-1:0] low_bits;
    pick     = $urandom_range(0, 99);
    kern     = 1'($urandom_range(0, 1));
    off      = 64'($urandom_range(0, region_pages(kern) - 1));
    low_bits = ADDR_W'($urandom_range(1, (1 << PAGE_SHIFT) - 1));
    if (pick < alloc_pct) begin
      send_op(MODE_ALLOC, kern, random_addr());
    end else if (pick < 85) begin
      send_op(MODE_FREE, kern, page_addr(kern, off));
    end else if (pick < 90) begin
      send_op(MODE_FREE, kern, page_addr(kern, off) | low_bits);
    end else if (pick < 93) begin
      if ($urandom_range(0, 1) == 1) begin
        send_op(MODE_FREE, kern, page_addr(kern, '1));
      end else begin
        send_op(MODE_FREE, kern, page_addr(kern, 64'(region_pages(kern))));
      end
    end else if (pick < 96) begin
      send_op(MODE_FREE, kern, page_addr(!kern, off));
    end else begin
      send_op(1'($urandom_range(0, 1)), kern, random_addr());
    end
  endtask

  // Result side. For each result it draws a hold-off, then takes the result. Once, after
  // a set number of results, it holds off for a long stretch while the sender keeps
  // offering items, so the output register fills and the block stalls its input.
  initial begin
    int hold_cycles;
    int taken;
    taken = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      hold_cycles = no_idle ? 0 : $urandom_range(0, 6);
      if (taken == HOLD_AFTER) begin
        hold_cycles = LONG_HOLD;
      end
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (hold_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      taken++;
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("two_region_page_frame_allocator regression: fail");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed items at the reset base. Right after reset every stack is full, so a
    // free of a valid page is a double free that the full check catches.
    send_op(MODE_FREE, SEL_KERN, page_addr(SEL_KERN, 64'(0)));
    send_op(MODE_FREE, SEL_USER, page_addr(SEL_USER, 64'(USER_PAGES - 1)));
    // Allocations ignore the address field; the highest page comes out first.
    send_op(MODE_ALLOC, SEL_KERN, '1);
    send_op(MODE_ALLOC, SEL_USER, '0);
    // Misaligned frees: lowest and highest bit below the page size.
    send_op(MODE_FREE, SEL_KERN, page_addr(SEL_KERN, 64'(KERNEL_PAGES - 1)) | ADDR_W'(1));
    send_op(MODE_FREE, SEL_KERN,
            page_addr(SEL_KERN, 64'(KERNEL_PAGES - 1)) | ADDR_W'(1 << (PAGE_SHIFT - 1)));
    // Frees just below the kernel region and just past each region, and a kernel page into the user region.
    send_op(MODE_FREE, SEL_KERN, page_addr(SEL_KERN, '1));
    send_op(MODE_FREE, SEL_KERN, page_addr(SEL_KERN, 64'(KERNEL_PAGES)));
    send_op(MODE_FREE, SEL_USER, page_addr(SEL_USER, 64'(USER_PAGES)));
    send_op(MODE_FREE, SEL_USER, page_addr(SEL_KERN, 64'(7)));
    // Return the allocated page, then a second free finds the stack full again.
    send_op(MODE_FREE, SEL_KERN, page_addr(SEL_KERN, 64'(KERNEL_PAGES - 1)));
    send_op(MODE_FREE, SEL_KERN, page_addr(SEL_KERN, 64'(5)));
    // A double free below full goes unnoticed: the same page is handed out twice.
    send_op(MODE_ALLOC, SEL_KERN, '0);
    send_op(MODE_ALLOC, SEL_KERN, '0);
    send_op(MODE_FREE, SEL_KERN, page_addr(SEL_KERN, 64'(300)));
    send_op(MODE_FREE, SEL_KERN, page_addr(SEL_KERN, 64'(300)));
    send_op(MODE_ALLOC, SEL_KERN, '0);
    send_op(MODE_ALLOC, SEL_KERN, '0);
    // Address extremes.
    send_op(MODE_FREE, SEL_USER, '1);
    send_op(MODE_FREE, SEL_USER, '0);
    send_op(MODE_FREE, SEL_USER, page_addr(SEL_USER, 64'(0)));

    // Base at zero: page address zero is the first kernel page.
    write_base('0);
    send_op(MODE_FREE, SEL_KERN, '0);
    repeat (100) send_random_op(45);

    // Base at its top value: kernel allocations wrap past the address space, and only the
    // first kernel page can be named by a free at all.
    write_base('1);
    send_op(MODE_ALLOC, SEL_KERN, '0);
    send_op(MODE_ALLOC, SEL_KERN, '0);
    send_op(MODE_ALLOC, SEL_USER, '0);
    send_op(MODE_FREE, SEL_KERN, page_addr(SEL_KERN, 64'(0)));
    send_op(MODE_FREE, SEL_USER, page_addr(SEL_USER, 64'(0)));
    repeat (80) send_random_op(45);

    // Random base, first with gaps and then back to back on both sides.
    write_base(BASE_W'({$urandom, $urandom}));
    repeat (60) send_random_op(45);
    no_idle = 1'b1;
    repeat (60) send_random_op(45);
    no_idle = 1'b0;

    // Base set so the user region runs off the top of the page number space.
    write_base('1 - BASE_W'(KERNEL_PAGES + USER_PAGES / 2));
    repeat (60) send_random_op(45);

    // Back to the reset base with free-heavy traffic.
    write_base(BASE_RESET);
    repeat (60) send_random_op(30);

    settle();
    if (mismatches == 0) begin
      $display("two_region_page_frame_allocator regression: pass");
    end else begin
      $display("two_region_page_frame_allocator regression: fail");
    end
    $finish;
  end

endmodule

### two_region_page_frame_allocator.f
design/tpfa_pkg.sv
design/two_region_page_frame_allocator.sv
sim/frame_alloc_checker.sv
sim/two_region_page_frame_allocator_tb.sv
